// ----- src/ptree_pkg.sv -----
// types, codes and fixed widths shared by the palindromic tree block
// no dependencies
package ptree_pkg;

    localparam int LETTER_W = 5;
    localparam int REPORT_W = 16;
    localparam int ROOT_EVEN = 0;
    localparam int ROOT_ODD = 1;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                restart;
    } t_in;

    typedef struct packed {
        logic [REPORT_W-1:0] distinct_count;
        logic [REPORT_W-1:0] suffix_pal_len;
        logic                full_res;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEN,
        ST_TXT,
        ST_CMP,
        ST_CADR,
        ST_CRD,
        ST_CVAL,
        ST_CCHK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic len_rd;
        logic txt;
        logic cmp;
        logic cadr;
        logic crd;
        logic cval;
        logic cchk;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic skip;
        logic jneg;
        logic match;
        logic phase;
        logic child_ok;
        logic out_free;
    } t_stat;

endpackage

// ----- src/palindromic_tree_insert.sv -----
// top level of the palindromic tree block: sequencer plus datapath
// depends on ptree_pkg, ptree_ctrl, ptree_dp
//
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_ready   i_in  (letter, restart)
// out      out  o_out_valid / i_out_ready o_out (distinct_count, suffix_pal_len, full_res)
//
// a letter is accepted, then each suffix-link step of each walk reads the length, reads the
// text and compares (the compare is skipped when the step falls before the start of the text),
// and each child lookup forms the address, reads the child, reads its parent and letter and
// checks it, then the result is emitted; the walks are amortised constant per letter
// dropped and out-of-range letters go from acceptance straight to the result
// after reset the child table is swept once, (MAX_LEN+2)*ALPHABET entries, input held off
// a stalled output holds the sequencer before the next letter is taken
module palindromic_tree_insert #(
    parameter int MAX_LEN  = 65535,
    parameter int ALPHABET = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ptree_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ptree_pkg::t_out o_out
);

    ptree_pkg::t_cmd  cmd;
    ptree_pkg::t_stat stat;

    // sequencer
    ptree_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // memories and walk datapath
    ptree_dp #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- src/ptree_ctrl.sv -----
// sequencer for the suffix-link walks, child lookups and node creation
// depends on ptree_pkg
module ptree_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ptree_pkg::t_stat i_stat,
    output ptree_pkg::t_cmd  o_cmd
);

    ptree_pkg::t_state r_state;
    ptree_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptree_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ptree_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = ptree_pkg::ST_IDLE;
                end
            end
            ptree_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.skip ? ptree_pkg::ST_OUT : ptree_pkg::ST_LEN;
                end
            end
            ptree_pkg::ST_LEN: begin
                o_cmd.len_rd = 1'b1;
                n_state = ptree_pkg::ST_TXT;
            end
            ptree_pkg::ST_TXT: begin
                o_cmd.txt = 1'b1;
                n_state = i_stat.jneg ? ptree_pkg::ST_LEN : ptree_pkg::ST_CMP;
            end
            ptree_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_stat.match ? ptree_pkg::ST_CADR : ptree_pkg::ST_LEN;
            end
            ptree_pkg::ST_CADR: begin
                o_cmd.cadr = 1'b1;
                n_state = ptree_pkg::ST_CRD;
            end
            ptree_pkg::ST_CRD: begin
                o_cmd.crd = 1'b1;
                n_state = ptree_pkg::ST_CVAL;
            end
            ptree_pkg::ST_CVAL: begin
                o_cmd.cval = 1'b1;
                n_state = ptree_pkg::ST_CCHK;
            end
            ptree_pkg::ST_CCHK: begin
                o_cmd.cchk = 1'b1;
                if (!i_stat.phase && !i_stat.child_ok) begin
                    n_state = ptree_pkg::ST_LEN;
                end else begin
                    n_state = ptree_pkg::ST_OUT;
                end
            end
            ptree_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ptree_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptree_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // input is taken only once the clearing pass is over
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptree_pkg::ST_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");
    // a walk step always follows a length read
    a_len_then_txt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.len_rd |=> o_cmd.txt)
        else $error("length read not followed by text step");
    // a skipped letter goes straight to the result
    a_skip_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.skip) |=> (r_state == ptree_pkg::ST_OUT))
        else $error("skipped letter did not go to output");
`endif

endmodule

// ----- src/ptree_dp.sv -----
// datapath: text, node and child memories, walk registers and result register
// depends on ptree_pkg
module ptree_dp #(
    parameter int MAX_LEN  = 65535,
    parameter int ALPHABET = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptree_pkg::t_in   i_in,
    input  ptree_pkg::t_cmd  i_cmd,
    output ptree_pkg::t_stat o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ptree_pkg::t_out  o_out
);

    localparam int NODE_CAP = MAX_LEN + 2;
    localparam int NCW      = $clog2(MAX_LEN + 3);
    localparam int NIW      = $clog2(NODE_CAP);
    localparam int TIW      = $clog2(MAX_LEN);
    localparam int TLW      = $clog2(MAX_LEN + 1);
    localparam int AW       = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int CD       = NODE_CAP * ALPHABET;
    localparam int CIW      = $clog2(CD);
    localparam int LW       = NCW + 1;
    localparam int JW       = LW + 1;

    // memories
    logic [AW-1:0]         text_mem  [MAX_LEN];
    logic signed [LW-1:0]  len_mem   [NODE_CAP];
    logic [NCW-1:0]        link_mem  [NODE_CAP];
    logic [NCW-1:0]        par_mem   [NODE_CAP];
    logic [AW-1:0]         chr_mem   [NODE_CAP];
    logic [NCW-1:0]        child_mem [CD];

    logic [CIW-1:0]        r_clr;
    logic [NCW-1:0]        r_count;
    logic [NCW-1:0]        r_last;
    logic signed [LW-1:0]  r_last_len;
    logic [TLW-1:0]        r_tlen;
    logic                  r_phase;
    logic                  r_full;
    logic [NCW-1:0]        r_v;
    logic [TLW-1:0]        r_pos;
    logic [AW-1:0]         r_c;
    logic signed [LW-1:0]  r_len_v;
    logic [NCW-1:0]        r_link_v;
    logic [NCW-1:0]        r_x;
    logic signed [LW-1:0]  r_xlen;
    logic [NCW-1:0]        r_xlink;
    logic [CIW-1:0]        r_addr;
    logic [CIW-1:0]        r_xaddr;
    logic [NCW-1:0]        r_cv;
    logic                  r_cin;
    logic                  r_out_valid;
    ptree_pkg::t_out       r_out;

    logic signed [LW-1:0]  r_len_q;
    logic [NCW-1:0]        r_link_q;
    logic [AW-1:0]         r_text_q;
    logic [NCW-1:0]        r_child_q;
    logic [NCW-1:0]        r_par_q;
    logic [AW-1:0]         r_chr_q;

    logic [7:0]            letter8;
    logic [AW-1:0]         c_in;
    logic                  bad_letter;
    logic                  full_eff;
    logic [TLW-1:0]        tlen_eff;
    logic [NCW-1:0]        count_eff;
    logic [NCW-1:0]        last_eff;
    logic signed [LW-1:0]  last_len_eff;
    logic signed [LW-1:0]  cur_len;
    logic [NCW-1:0]        cur_link;
    logic signed [JW-1:0]  j;
    logic                  child_ok;
    logic signed [LW-1:0]  new_len;
    logic [NCW-1:0]        new_link;
    logic [31:0]           len32;
    logic [31:0]           cnt32;

    // letter decode and effective state after a restart
    always_comb begin
        letter8      = {{(8 - ptree_pkg::LETTER_W){1'b0}}, i_in.letter};
        c_in         = letter8[AW-1:0];
        bad_letter   = ({24'd0, letter8} >= 32'(ALPHABET));
        tlen_eff     = i_in.restart ? '0 : r_tlen;
        count_eff    = i_in.restart ? NCW'(2) : r_count;
        last_eff     = i_in.restart ? NCW'(ptree_pkg::ROOT_ODD) : r_last;
        last_len_eff = i_in.restart ? -LW'(1) : r_last_len;
        full_eff     = !bad_letter && (32'(tlen_eff) >= 32'(MAX_LEN));
    end

    // node length and link, roots are constants
    always_comb begin
        if (r_v == NCW'(ptree_pkg::ROOT_EVEN)) begin
            cur_len  = '0;
            cur_link = NCW'(ptree_pkg::ROOT_ODD);
        end else if (r_v == NCW'(ptree_pkg::ROOT_ODD)) begin
            cur_len  = -LW'(1);
            cur_link = NCW'(ptree_pkg::ROOT_EVEN);
        end else begin
            cur_len  = r_len_q;
            cur_link = r_link_q;
        end
        j = JW'(signed'({1'b0, r_pos})) - JW'(cur_len) - JW'(1);
    end

    // a child entry counts only if the node it names is live and belongs to this edge
    always_comb begin
        child_ok = r_cin && (r_par_q == r_v) && (r_chr_q == r_c);
        new_len  = r_xlen + LW'(2);
        new_link = child_ok ? r_cv : NCW'(ptree_pkg::ROOT_EVEN);
    end

    // text memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !bad_letter && !full_eff) begin
            text_mem[tlen_eff[TIW-1:0]] <= c_in;
        end
        if (i_cmd.txt) begin
            r_text_q <= text_mem[j[TIW-1:0]];
        end
    end

    // node length and suffix link memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.cchk && r_phase) begin
            len_mem[r_count[NIW-1:0]]  <= new_len;
            link_mem[r_count[NIW-1:0]] <= new_link;
        end
        if (i_cmd.len_rd) begin
            r_len_q  <= len_mem[r_v[NIW-1:0]];
            r_link_q <= link_mem[r_v[NIW-1:0]];
        end
    end

    // parent and edge letter of each node
    always_ff @(posedge i_clk) begin
        if (i_cmd.cchk && r_phase) begin
            par_mem[r_count[NIW-1:0]] <= r_x;
            chr_mem[r_count[NIW-1:0]] <= r_c;
        end
        if (i_cmd.cval) begin
            r_par_q <= par_mem[r_child_q[NIW-1:0]];
            r_chr_q <= chr_mem[r_child_q[NIW-1:0]];
        end
    end

    // child table, swept to zero after reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            child_mem[r_clr] <= '0;
        end else if (i_cmd.cchk && r_phase) begin
            child_mem[r_xaddr] <= r_count;
        end
        if (i_cmd.crd) begin
            r_child_q <= child_mem[r_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= NCW'(2);
            r_last      <= NCW'(ptree_pkg::ROOT_ODD);
            r_last_len  <= -LW'(1);
            r_tlen      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + CIW'(1);
            end
            if (i_cmd.accept) begin
                r_count    <= count_eff;
                r_last     <= last_eff;
                r_last_len <= last_len_eff;
                r_phase    <= 1'b0;
                if (!bad_letter && !full_eff) begin
                    r_tlen <= tlen_eff + TLW'(1);
                end else begin
                    r_tlen <= tlen_eff;
                end
            end
            if (i_cmd.cchk) begin
                if (!r_phase && child_ok) begin
                    r_last     <= r_cv;
                    r_last_len <= new_len;
                end else if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_last     <= r_count;
                    r_last_len <= new_len;
                    r_count    <= r_count + NCW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_full <= full_eff;
            r_v    <= last_eff;
            r_pos  <= tlen_eff;
            r_c    <= c_in;
        end
        if (i_cmd.txt) begin
            r_len_v  <= cur_len;
            r_link_v <= cur_link;
            if (j < 0) begin
                r_v <= cur_link;
            end
        end
        if (i_cmd.cmp) begin
            if (r_text_q == r_c) begin
                if (!r_phase) begin
                    r_x     <= r_v;
                    r_xlen  <= r_len_v;
                    r_xlink <= r_link_v;
                end
            end else begin
                r_v <= r_link_v;
            end
        end
        if (i_cmd.cadr) begin
            r_addr <= CIW'(r_v) * CIW'(ALPHABET) + CIW'(r_c);
            if (!r_phase) begin
                r_xaddr <= CIW'(r_v) * CIW'(ALPHABET) + CIW'(r_c);
            end
        end
        if (i_cmd.cval) begin
            r_cv  <= r_child_q;
            r_cin <= (r_child_q >= NCW'(2)) && (r_child_q < r_count);
        end
        if (i_cmd.cchk && !r_phase && !child_ok) begin
            r_v <= r_xlink;
        end
    end

    // result register
    always_comb begin
        cnt32 = 32'(r_count) - 32'd2;
        len32 = (r_last_len < 0) ? 32'd0 : 32'(r_last_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.distinct_count <= cnt32[ptree_pkg::REPORT_W-1:0];
            r_out.suffix_pal_len <= len32[ptree_pkg::REPORT_W-1:0];
            r_out.full_res       <= r_full;
        end
    end

    always_comb begin
        o_stat.clr_done = (r_clr == CIW'(CD - 1));
        o_stat.skip     = bad_letter || full_eff;
        o_stat.jneg     = (j < 0);
        o_stat.match    = (r_text_q == r_c);
        o_stat.phase    = r_phase;
        o_stat.child_ok = child_ok;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // node count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= NCW'(2)) && (32'(r_count) <= 32'(NODE_CAP)))
        else $error("node count out of range");
    // text length never exceeds capacity
    a_tlen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tlen) <= 32'(MAX_LEN))
        else $error("text length beyond capacity");
    // a new node always comes with one new letter of text
    a_node_per_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(r_tlen) + 32'd2)
        else $error("more nodes than letters");
    // emitted result is presented next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result not presented after emit");
`endif

endmodule
